// ----- rtl/scbp_pkg.sv -----
// size class buffer pool: shared types and codes
// transaction kinds, result status codes, per-class control struct
// no dependencies
`default_nettype none

package scbp_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_INIT     = 2'd2,
    KIND_TEARDOWN = 2'd3
  } scbp_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNINIT    = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NULL      = 3'd4
  } scbp_status_e;

  localparam int unsigned NUM_CFG_CLASSES = 4;
  localparam int unsigned CAP_W           = 16;
  localparam int unsigned CFG_BUFS_W      = 5;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CLS_W           = 2;
  localparam int unsigned FIDX_W          = 4;
  localparam int unsigned USED_W          = 5;

  // register indexes: capacities first, then buffer counts
  localparam logic [CFG_IDX_W-1:0] REG_CAP_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFS_BASE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 8'd8;

  typedef struct packed {
    logic init;
    logic clear;
    logic pop;
    logic push;
  } scbp_class_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/scbp_class.sv -----
// size class buffer pool: one size class
// lifo free stack, stack top, latched buffer count and in-use marks
// depends on scbp_pkg
`default_nettype none

module scbp_class
  import scbp_pkg::*;
#(
  parameter int unsigned BUFS  = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scbp_class_ctrl_t ctrl_i,
  input  wire logic [CNT_W-1:0] init_count_i,
  input  wire logic [IDX_W-1:0] idx_i,
  output logic      [CNT_W-1:0] top_o,
  output logic      [CNT_W-1:0] total_o,
  output logic      [IDX_W-1:0] head_o,
  output logic                  busy_o
);

  logic [IDX_W-1:0] stack_q [BUFS];
  logic [CNT_W-1:0] top_q, top_d;
  logic [CNT_W-1:0] total_q;
  logic [BUFS-1:0]  used_q, used_d;
  logic [CNT_W-1:0] top_m1;

  assign top_m1  = top_q - CNT_W'(1);
  assign head_o  = stack_q[top_m1[IDX_W-1:0]];
  assign busy_o  = used_q[idx_i];
  assign top_o   = top_q;
  assign total_o = total_q;

  always_comb begin
    top_d  = top_q;
    used_d = used_q;
    if (ctrl_i.init) begin
      top_d  = init_count_i;
      used_d = '0;
    end else if (ctrl_i.clear) begin
      top_d  = '0;
      used_d = '0;
    end else if (ctrl_i.pop) begin
      top_d          = top_m1;
      used_d[head_o] = 1'b1;
    end else if (ctrl_i.push) begin
      top_d         = top_q + CNT_W'(1);
      used_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      total_q <= '0;
      used_q  <= '0;
    end else begin
      top_q  <= top_d;
      used_q <= used_d;
      if (ctrl_i.init) begin
        total_q <= init_count_i;
      end
    end
  end

  // init loads count-1 down to 0 so pops hand out index 0 upward
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      for (int k = 0; k < int'(BUFS); k++) begin
        stack_q[k] <= IDX_W'(int'(init_count_i) - 1 - k);
      end
    end else if (ctrl_i.push) begin
      stack_q[top_q[IDX_W-1:0]] <= idx_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/size_class_buffer_pool.sv -----
// size class buffer pool: top level
// input register, class select and free checks, result register
// depends on scbp_pkg and scbp_class
//
// usage
//   s_axis carries requests: tuser holds the kind (allocate, free, init,
//   teardown), tdata the request size and the handle to free. m_axis carries
//   one result per request: status, granted class and index, buffers in use.
//   the cfg channel writes capacities (index 0..3), buffer counts (index 4..7);
//   it is always ready; the user must write it only while idle (not enforced).
// timing
//   one transaction per cycle sustained while m_axis_tready stays high; a
//   request's result passes the input register, then the result register.
//   the stack tops and in-use marks are flip-flops, so the next request sees
//   this one's effect.
// reset
//   the pool is uninitialized until an init request; registers return to
//   64/256/1024/4096 bytes and 16 buffers per class.
// stalls
//   while m_axis_tready is low the result holds and one more request is
//   taken into the input register, then s_axis_tready drops.
`default_nettype none

module size_class_buffer_pool
  import scbp_pkg::*;
#(
  parameter int unsigned NUM_CLASSES       = 4,
  parameter int unsigned BUFFERS_PER_CLASS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // request_size[15:0], handle_present[16], free_class[18:17], free_index[22:19]
  input  wire logic [23:0]           s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status[2:0], alloc_class[4:3], alloc_index[8:5], class_used[13:9]
  output logic [15:0]                m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W  = (BUFFERS_PER_CLASS > 1) ? $clog2(BUFFERS_PER_CLASS) : 1;
  localparam int unsigned CNT_W  = $clog2(BUFFERS_PER_CLASS + 1);
  localparam int unsigned FIX_W  = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
  localparam int unsigned UW     = (CNT_W > USED_W) ? CNT_W : USED_W;

  // configuration registers
  logic [CAP_W-1:0]      cap_q  [NUM_CFG_CLASSES];
  logic [CFG_BUFS_W-1:0] bufs_q [NUM_CFG_CLASSES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q[0]  <= 16'd64;
      cap_q[1]  <= 16'd256;
      cap_q[2]  <= 16'd1024;
      cap_q[3]  <= 16'd4096;
      bufs_q[0] <= 5'd16;
      bufs_q[1] <= 5'd16;
      bufs_q[2] <= 5'd16;
      bufs_q[3] <= 5'd16;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < REG_BUFS_BASE) begin
        cap_q[2'(cfg_index_i - REG_CAP_BASE)] <= cfg_data_i;
      end else if (cfg_index_i < REG_END) begin
        bufs_q[2'(cfg_index_i - REG_BUFS_BASE)] <= cfg_data_i[CFG_BUFS_W-1:0];
      end
    end
  end

  // input register
  logic             in_valid_q;
  scbp_kind_e       kind_q;
  logic [CAP_W-1:0] size_q;
  logic             present_q;
  logic [CLS_W-1:0] fcls_q;
  logic [FIDX_W-1:0] fidx_q;
  logic             out_valid_q;
  logic             proceed;
  logic             s_fire;

  assign proceed       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proceed;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q    <= scbp_kind_e'(s_axis_tuser);
      size_q    <= s_axis_tdata[15:0];
      present_q <= s_axis_tdata[16];
      fcls_q    <= s_axis_tdata[18:17];
      fidx_q    <= s_axis_tdata[22:19];
    end
  end

  // per-class values and storage
  logic [CAP_W-1:0]  class_cap   [NUM_CLASSES];
  logic [CNT_W-1:0]  class_count [NUM_CLASSES];
  logic [CNT_W-1:0]  top         [NUM_CLASSES];
  logic [CNT_W-1:0]  total       [NUM_CLASSES];
  logic [IDX_W-1:0]  head        [NUM_CLASSES];
  logic              busy        [NUM_CLASSES];
  scbp_class_ctrl_t  ctrl        [NUM_CLASSES];
  logic [FIX_W-1:0]  fidx_ext;
  logic [IDX_W-1:0]  idx;

  assign fidx_ext = FIX_W'(fidx_q);
  assign idx      = fidx_ext[IDX_W-1:0];

  for (genvar g = 0; g < int'(NUM_CLASSES); g++) begin : g_class
    if (g < int'(NUM_CFG_CLASSES)) begin : g_cfg
      assign class_cap[g]   = cap_q[g];
      assign class_count[g] = (int'(bufs_q[g]) > int'(BUFFERS_PER_CLASS)) ?
                              CNT_W'(BUFFERS_PER_CLASS) : CNT_W'(bufs_q[g]);
    end else begin : g_none
      assign class_cap[g]   = '0;
      assign class_count[g] = '0;
    end

    scbp_class #(
      .BUFS  (BUFFERS_PER_CLASS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_class (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .init_count_i (class_count[g]),
      .idx_i        (idx),
      .top_o        (top[g]),
      .total_o      (total[g]),
      .head_o       (head[g]),
      .busy_o       (busy[g])
    );
  end

  // decision logic
  logic               pool_ready_q;
  logic               too_large;
  logic               granted;
  logic [NUM_CLASSES-1:0] grant;
  logic [CLS_W-1:0]   grant_cls;
  logic [IDX_W-1:0]   grant_head;
  logic [CNT_W-1:0]   grant_used;
  logic               fcls_valid;
  logic [CNT_W-1:0]   f_top;
  logic [CNT_W-1:0]   f_total;
  logic               f_busy;
  logic               push_ok;
  logic [CNT_W-1:0]   free_used;

  always_comb begin
    too_large  = 1'b0;
    granted    = 1'b0;
    grant      = '0;
    grant_cls  = '0;
    grant_head = '0;
    grant_used = '0;
    fcls_valid = 1'b0;
    f_top      = '0;
    f_total    = '0;
    f_busy     = 1'b0;
    for (int c = 0; c < int'(NUM_CLASSES); c++) begin
      if (c == int'(NUM_CLASSES) - 1) begin
        too_large = size_q > class_cap[c];
      end
      if (!granted && size_q <= class_cap[c] && top[c] != '0) begin
        granted    = 1'b1;
        grant[c]   = 1'b1;
        grant_cls  = CLS_W'(c);
        grant_head = head[c];
        grant_used = total[c] - top[c] + CNT_W'(1);
      end
      if (int'(fcls_q) == c) begin
        fcls_valid = 1'b1;
        f_top      = top[c];
        f_total    = total[c];
        f_busy     = busy[c];
      end
    end
  end

  assign push_ok = pool_ready_q && kind_q == KIND_FREE && present_q && fcls_valid &&
                   int'(fidx_q) < int'(f_total) && f_busy && f_top < f_total;
  assign free_used = f_total - f_top - CNT_W'(push_ok);

  always_comb begin
    for (int c = 0; c < int'(NUM_CLASSES); c++) begin
      ctrl[c].init  = proceed && kind_q == KIND_INIT;
      ctrl[c].clear = proceed && pool_ready_q && kind_q == KIND_TEARDOWN;
      ctrl[c].pop   = proceed && pool_ready_q && kind_q == KIND_ALLOC &&
                      !too_large && grant[c];
      ctrl[c].push  = proceed && push_ok && int'(fcls_q) == c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_ready_q <= 1'b0;
    end else if (proceed) begin
      if (kind_q == KIND_INIT) begin
        pool_ready_q <= 1'b1;
      end else if (kind_q == KIND_TEARDOWN) begin
        pool_ready_q <= 1'b0;
      end
    end
  end

  // result fields
  scbp_status_e     status_d;
  logic [CLS_W-1:0] acls_d;
  logic [FIX_W-1:0] aidx_d;
  logic [UW-1:0]    used_d;

  always_comb begin
    status_d = ST_OK;
    acls_d   = '0;
    aidx_d   = '0;
    used_d   = '0;
    if (kind_q == KIND_INIT) begin
      status_d = ST_OK;
    end else if (!pool_ready_q) begin
      status_d = ST_UNINIT;
    end else begin
      unique case (kind_q)
        KIND_ALLOC: begin
          if (too_large) begin
            status_d = ST_TOO_LARGE;
          end else if (!granted) begin
            status_d = ST_EXHAUSTED;
          end else begin
            acls_d = grant_cls;
            aidx_d = FIX_W'(grant_head);
            used_d = UW'(grant_used);
          end
        end
        KIND_FREE: begin
          if (!present_q) begin
            status_d = ST_NULL;
          end else if (fcls_valid) begin
            used_d = UW'(free_used);
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // result register
  logic [2:0]        status_q;
  logic [CLS_W-1:0]  acls_q;
  logic [FIDX_W-1:0] aidx_q;
  logic [USED_W-1:0] used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      status_q <= status_d;
      acls_q   <= acls_d;
      aidx_q   <= aidx_d[FIDX_W-1:0];
      used_q   <= used_d[USED_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, used_q, aidx_q, acls_q, status_q};

endmodule

`default_nettype wire

// ----- verif/tb_size_class_buffer_pool.sv -----
`timescale 1ns / 1ps
// testbench for size_class_buffer_pool: directed and random request streams, each
// result checked against an allocator model kept inside the bench
// depends on scbp_pkg and the size_class_buffer_pool rtl

module tb_size_class_buffer_pool;
  import scbp_pkg::*;

  localparam int unsigned NUM_CLASSES       = 4;
  localparam int unsigned BUFFERS_PER_CLASS = 16;
  localparam int unsigned SLOTS             = NUM_CLASSES * BUFFERS_PER_CLASS;

  typedef struct {
    scbp_kind_e        kind;
    logic [CAP_W-1:0]  size;
    logic              present;
    logic [CLS_W-1:0]  cls;
    logic [FIDX_W-1:0] idx;
  } pool_req_t;

  typedef struct {
    scbp_status_e      status;
    logic [CLS_W-1:0]  cls;
    logic [FIDX_W-1:0] idx;
    logic [USED_W-1:0] used;
  } pool_reply_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned mismatches    = 0;
  pool_reply_t awaited_replies[$];

  // allocator model state
  logic [CAP_W-1:0]      class_cap   [NUM_CLASSES];
  logic [CFG_BUFS_W-1:0] class_bufs  [NUM_CLASSES];
  logic                  pool_ready;
  logic [FIDX_W-1:0]     free_stack  [SLOTS];
  logic [USED_W-1:0]     free_top    [NUM_CLASSES];
  logic [USED_W-1:0]     class_total [NUM_CLASSES];
  logic [SLOTS-1:0]      in_use;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  size_class_buffer_pool #(
    .NUM_CLASSES      (NUM_CLASSES),
    .BUFFERS_PER_CLASS(BUFFERS_PER_CLASS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic pool_reply_t model_pool_request(input pool_req_t r);
    pool_reply_t res;
    int unsigned c, k, n, slot;
    logic        granted;
    res.status = ST_OK;
    res.cls    = '0;
    res.idx    = '0;
    res.used   = '0;
    granted    = 1'b0;
    if (r.kind == KIND_INIT) begin
      in_use = '0;
      for (c = 0; c < NUM_CLASSES; c++) begin
        n = (class_bufs[c] > BUFFERS_PER_CLASS) ? BUFFERS_PER_CLASS : class_bufs[c];
        class_total[c] = USED_W'(n);
        for (k = 0; k < n; k++) begin
          free_stack[c * BUFFERS_PER_CLASS + k] = FIDX_W'(n - 1 - k);
        end
        free_top[c] = USED_W'(n);
      end
      pool_ready = 1'b1;
    end else if (!pool_ready) begin
      res.status = ST_UNINIT;
    end else if (r.kind == KIND_TEARDOWN) begin
      pool_ready = 1'b0;
      in_use     = '0;
      for (c = 0; c < NUM_CLASSES; c++) free_top[c] = '0;
    end else if (r.kind == KIND_ALLOC) begin
      if (r.size > class_cap[NUM_CLASSES-1]) begin
        res.status = ST_TOO_LARGE;
      end else begin
        res.status = ST_EXHAUSTED;
        for (c = 0; c < NUM_CLASSES; c++) begin
          if (!granted && r.size <= class_cap[c] && free_top[c] != 0) begin
            granted     = 1'b1;
            free_top[c] = free_top[c] - 1'b1;
            slot        = c * BUFFERS_PER_CLASS + free_top[c];
            res.idx     = free_stack[slot];
            in_use[c * BUFFERS_PER_CLASS + res.idx] = 1'b1;
            res.status  = ST_OK;
            res.cls     = CLS_W'(c);
            res.used    = class_total[c] - free_top[c];
          end
        end
      end
    end else if (!r.present) begin
      res.status = ST_NULL;
    end else begin
      c    = r.cls;
      slot = c * BUFFERS_PER_CLASS + r.idx;
      if (r.idx < class_total[c] && in_use[slot] && free_top[c] < class_total[c]) begin
        in_use[slot] = 1'b0;
        free_stack[c * BUFFERS_PER_CLASS + free_top[c]] = r.idx;
        free_top[c] = free_top[c] + 1'b1;
      end
      res.used = class_total[c] - free_top[c];
    end
    return res;
  endfunction

  function automatic pool_req_t request(input scbp_kind_e kind, input logic [CAP_W-1:0] size,
                                        input logic present, input logic [CLS_W-1:0] cls,
                                        input logic [FIDX_W-1:0] idx);
    pool_req_t r;
    r.kind    = kind;
    r.size    = size;
    r.present = present;
    r.cls     = cls;
    r.idx     = idx;
    return r;
  endfunction

  task automatic send_request(input pool_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {1'b0, r.idx, r.cls, r.present, r.size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_replies.push_back(model_pool_request(r));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // capacities and counts packed class 0 in the low bits; also hits an unused index
  task automatic configure_pool(input logic [NUM_CLASSES*CAP_W-1:0] caps,
                                input logic [NUM_CLASSES*CFG_BUFS_W-1:0] bufs);
    reg_write_t  w[$];
    reg_write_t  e;
    int unsigned c;
    for (c = 0; c < NUM_CLASSES; c++) begin
      e.index = CFG_IDX_W'(REG_CAP_BASE + c);
      e.data  = caps[c*CAP_W +: CAP_W];
      w.push_back(e);
      e.index = CFG_IDX_W'(REG_BUFS_BASE + c);
      e.data  = CFG_DATA_W'($urandom);
      e.data[CFG_BUFS_W-1:0] = bufs[c*CFG_BUFS_W +: CFG_BUFS_W];
      w.push_back(e);
    end
    e.index = CFG_IDX_W'(REG_END + $urandom_range(255 - REG_END));
    e.data  = CFG_DATA_W'($urandom);
    w.push_back(e);
    wait_idle();
    foreach (w[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w[i].index;
      cfg_data_i  <= w[i].data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (w[i].index < REG_BUFS_BASE) begin
        class_cap[w[i].index - REG_CAP_BASE] = w[i].data;
      end else if (w[i].index < REG_END) begin
        class_bufs[w[i].index - REG_BUFS_BASE] = w[i].data[CFG_BUFS_W-1:0];
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_uninitialized();
    send_request(request(KIND_ALLOC, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd0, 4'd0));
    send_request(request(KIND_FREE, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_TEARDOWN, 16'd0, 1'b0, 2'd0, 4'd0));
  endtask

  task automatic test_grants_and_frees();
    send_request(request(KIND_INIT, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd64, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd65, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd4096, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd4097, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'hffff, 1'b0, 2'd3, 4'hf));
    send_request(request(KIND_FREE, 16'hffff, 1'b0, 2'd0, 4'd1));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd0, 4'd1));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd0, 4'd1));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd3, 4'hf));
    send_request(request(KIND_ALLOC, 16'd1, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_INIT, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd256, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_TEARDOWN, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd1, 4'd0));
  endtask

  task automatic test_exhaustion();
    configure_pool({16'd4096, 16'd1024, 16'd256, 16'd64}, {5'd1, 5'd2, 5'd0, 5'd1});
    send_request(request(KIND_INIT, 16'd0, 1'b0, 2'd0, 4'd0));
    repeat (5) send_request(request(KIND_ALLOC, 16'd0, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd300, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd1, 4'd0));
    send_request(request(KIND_FREE, 16'd0, 1'b1, 2'd2, 4'd0));
    send_request(request(KIND_ALLOC, 16'd2000, 1'b0, 2'd0, 4'd0));
    send_request(request(KIND_ALLOC, 16'd1000, 1'b0, 2'd0, 4'd0));
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    pool_req_t   r;
    int unsigned i, pick, c, s;
    int unsigned busy[$];
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (i = 0; i < n; i++) begin
      r.kind    = scbp_kind_e'($urandom_range(3));
      r.size    = CAP_W'($urandom);
      r.present = 1'($urandom);
      r.cls     = CLS_W'($urandom);
      r.idx     = FIDX_W'($urandom);
      pick      = $urandom_range(99);
      if (!pool_ready && pick < 70) begin
        r.kind = KIND_INIT;
      end else if (pick < 50) begin
        r.kind = KIND_ALLOC;
        c = $urandom_range(NUM_CLASSES - 1);
        case ($urandom_range(3))
          0: r.size = class_cap[c];
          1: r.size = class_cap[c] + 1'b1;
          2: r.size = CAP_W'($urandom_range(class_cap[c]));
          default: ;
        endcase
      end else if (pick < 92) begin
        r.kind = KIND_FREE;
        if (pick < 88) begin
          busy.delete();
          for (s = 0; s < SLOTS; s++) if (in_use[s]) busy.push_back(s);
          if (busy.size() != 0) begin
            s         = busy[$urandom_range(busy.size() - 1)];
            r.present = 1'b1;
            r.cls     = CLS_W'(s / BUFFERS_PER_CLASS);
            r.idx     = FIDX_W'(s % BUFFERS_PER_CLASS);
          end
        end
      end else if (pick < 96) begin
        r.kind = KIND_INIT;
      end else if (pick < 99) begin
        r.kind = KIND_TEARDOWN;
      end
      send_request(r);
    end
  endtask

  always @(posedge clk_i) begin : reply_check
    pool_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing outstanding, tdata %h", $realtime, m_axis_tdata);
        end
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[4:3] !== want.cls ||
            m_axis_tdata[8:5] !== want.idx || m_axis_tdata[13:9] !== want.used) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected status %0d class %0d index %0d used %0d", $realtime,
                     want.status, want.cls, want.idx, want.used);
            $display("%0t: actual   status %0d class %0d index %0d used %0d", $realtime,
                     m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tdata[8:5],
                     m_axis_tdata[13:9]);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    logic [NUM_CLASSES*CAP_W-1:0]      caps;
    logic [NUM_CLASSES*CFG_BUFS_W-1:0] bufs;
    int unsigned                       v[$];
    int unsigned                       c;
    class_cap  = '{16'd64, 16'd256, 16'd1024, 16'd4096};
    class_bufs = '{5'd16, 5'd16, 5'd16, 5'd16};
    pool_ready = 1'b0;
    in_use     = '0;
    for (c = 0; c < NUM_CLASSES; c++) begin
      free_top[c]    = '0;
      class_total[c] = '0;
    end
    for (c = 0; c < SLOTS; c++) free_stack[c] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_uninitialized();
    test_grants_and_frees();
    test_exhaustion();

    configure_pool({16'd4096, 16'd1024, 16'd256, 16'd64}, {5'd5, 5'd2, 5'd3, 5'd4});
    test_random_traffic(340, 14, 87);

    configure_pool({16'hffff, 16'hffff, 16'd0, 16'd0}, {5'd31, 5'd0, 5'd1, 5'd16});
    test_random_traffic(340, 87, 14);

    v.delete();
    for (c = 0; c < NUM_CLASSES; c++) v.push_back($urandom_range(16'hffff));
    if ($urandom_range(1)) v.sort();
    for (c = 0; c < NUM_CLASSES; c++) begin
      caps[c*CAP_W +: CAP_W]                = CAP_W'(v[c]);
      bufs[c*CFG_BUFS_W +: CFG_BUFS_W]      = CFG_BUFS_W'($urandom_range(31));
    end
    configure_pool(caps, bufs);
    test_random_traffic(340, 0, 0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- size_class_buffer_pool.f -----
rtl/scbp_pkg.sv
rtl/scbp_class.sv
rtl/size_class_buffer_pool.sv
verif/tb_size_class_buffer_pool.sv
